### hdl/lfe_pkg.sv
`default_nettype none

package lfe_pkg;

    localparam int POS_W = 7;
    localparam int OFFSET_W = 7;
    localparam int SIZE_W = 4;
    localparam int VALUE_W = 32;
    localparam int MAX_OFFSET_DEF = 64;
    localparam logic [POS_W-1:0] POS_LIMIT = 7'd127;
    localparam logic [POS_W-1:0] VARINT_MAX = 7'd5;
    localparam int VARINT_BITS = 7;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_LONG    = 3'd3,
        ST_BADSIZE = 3'd4
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] acc;
        logic               reported;
    } frame_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

### hdl/lfe_step.sv
`default_nettype none

module lfe_step #(
    parameter int MAX_OFFSET = lfe_pkg::MAX_OFFSET_DEF
) (
    input  wire lfe_pkg::frame_t                      cur,
    input  wire logic [lfe_pkg::OFFSET_W-1:0]         field_offset,
    input  wire logic signed [lfe_pkg::SIZE_W-1:0]    field_size,
    input  wire logic [7:0]                           data_byte,
    input  wire logic                                 last_byte,
    output lfe_pkg::frame_t                           nxt,
    output logic                                      emit,
    output lfe_pkg::result_t                          res
);
    import lfe_pkg::*;

    localparam logic [7:0] MAX_OFF_L = 8'(MAX_OFFSET);

    logic [7:0]         off;
    logic [7:0]         pos_ext;
    logic [7:0]         idx_full;
    logic [POS_W-1:0]   idx;
    logic               in_field;
    logic               neg;
    logic               varint;
    logic [3:0]         neg_mag;
    logic [3:0]         mag;
    logic [3:0]         mag_m1;
    logic               size_ok;
    logic [4:0]         var_shamt;
    logic [VALUE_W-1:0] var_sum;
    logic [VALUE_W-1:0] le_val;
    logic [VALUE_W-1:0] be_val;

    assign off      = ({1'b0, field_offset} > MAX_OFF_L) ? MAX_OFF_L : {1'b0, field_offset};
    assign pos_ext  = {1'b0, cur.pos};
    assign idx_full = pos_ext - off;
    assign idx      = idx_full[POS_W-1:0];
    assign in_field = (pos_ext >= off) && (cur.pos != POS_LIMIT);

    assign neg     = field_size[SIZE_W-1];
    assign varint  = (field_size == '0);
    assign neg_mag = 4'(-field_size);
    assign mag     = neg ? ((neg_mag == 4'd0) ? 4'd8 : neg_mag) : field_size;
    assign mag_m1  = mag - 4'd1;
    assign size_ok = varint || (mag == 4'd1) || (mag == 4'd2) || (mag == 4'd4);

    assign var_shamt = {2'b00, idx[2:0]} * 5'(VARINT_BITS);
    assign var_sum   = cur.acc + ({25'b0, data_byte[6:0]} << var_shamt);
    assign le_val    = cur.acc | ({24'b0, data_byte} << {idx[1:0], 3'b000});
    assign be_val    = {cur.acc[VALUE_W-9:0], data_byte};

    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        res  = '{value: '0, status: ST_OK};
        if (!cur.reported)
        begin
            if (in_field)
            begin
                if (varint)
                begin
                    if (idx < VARINT_MAX)
                    begin
                        nxt.acc = var_sum;
                        if (!data_byte[7])
                        begin
                            emit         = 1'b1;
                            res          = '{value: var_sum, status: ST_OK};
                            nxt.reported = 1'b1;
                        end
                        else if (idx == VARINT_MAX - 7'd1)
                        begin
                            emit         = 1'b1;
                            res          = '{value: '0, status: ST_LONG};
                            nxt.reported = 1'b1;
                        end
                    end
                end
                else if (idx < {3'b000, mag})
                begin
                    if (!size_ok)
                    begin
                        if (idx == {3'b000, mag_m1})
                        begin
                            emit         = 1'b1;
                            res          = '{value: '0, status: ST_BADSIZE};
                            nxt.reported = 1'b1;
                        end
                    end
                    else
                    begin
                        nxt.acc = neg ? be_val : le_val;
                        if (idx == {3'b000, mag_m1})
                        begin
                            emit         = 1'b1;
                            res          = '{value: nxt.acc, status: ST_OK};
                            nxt.reported = 1'b1;
                        end
                    end
                end
            end
            if (cur.pos != POS_LIMIT)
            begin
                nxt.pos = cur.pos + 7'd1;
            end
            if (!nxt.reported && last_byte)
            begin
                emit = 1'b1;
                res  = '{value: '0,
                         status: (varint && ({1'b0, nxt.pos} >= off)) ? ST_TRUNC : ST_SHORT};
            end
        end
        if (last_byte)
        begin
            nxt = '0;
        end
    end

endmodule

`default_nettype wire

### hdl/length_field_extractor.sv
// Output: a result is registered into the result buffer when the byte that completes its request is accepted.
// Throughput: one byte per cycle; the two-entry result buffer keeps byte_ready high while a
// single result waits, and byte_ready drops only when both entries are full.
// Reset: rst_n clears the frame state and the result buffer and sets field_offset to 0 and
// field_size to 2.
`default_nettype none

module length_field_extractor #(
    parameter int MAX_OFFSET = lfe_pkg::MAX_OFFSET_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  wire logic                              byte_valid,
    output logic                                   byte_ready,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              last_byte,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [lfe_pkg::VALUE_W-1:0]            length_value,
    output logic [2:0]                             status
);
    import lfe_pkg::*;

    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_SIZE   = 1'b1;

    logic [OFFSET_W-1:0]      field_offset_reg;
    logic signed [SIZE_W-1:0] field_size_reg;
    frame_t                   frame_reg;
    frame_t                   frame_next;
    logic                     main_valid_reg;
    logic                     main_valid_next;
    result_t                  main_reg;
    result_t                  main_next;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    result_t                  skid_reg;
    result_t                  skid_next;
    frame_t                   step_frame;
    logic                     step_emit;
    result_t                  step_res;
    logic                     cfg_write;
    logic                     accept;
    logic                     push;
    logic                     pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_OFFSET: prdata = {25'b0, field_offset_reg};
            REG_SIZE:   prdata = {{28{field_size_reg[SIZE_W-1]}}, field_size_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_offset_reg <= '0;
            field_size_reg   <= 4'sd2;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SIZE)
            begin
                field_size_reg <= pwdata[SIZE_W-1:0];
            end
            else
            begin
                field_offset_reg <= pwdata[OFFSET_W-1:0];
            end
        end
    end

    lfe_step #(
        .MAX_OFFSET(MAX_OFFSET)
    ) u_step (
        .cur         (frame_reg),
        .field_offset(field_offset_reg),
        .field_size  (field_size_reg),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .nxt         (step_frame),
        .emit        (step_emit),
        .res         (step_res)
    );

    assign byte_ready   = !skid_valid_reg;
    assign accept       = byte_valid && byte_ready;
    assign push         = accept && step_emit;
    assign pop          = main_valid_reg && result_ready;
    assign frame_next   = accept ? step_frame : frame_reg;

    assign result_valid = main_valid_reg;
    assign length_value = main_reg.value;
    assign status       = main_reg.status;

    // The skid entry only fills when the main entry is held, and it always drains first.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = step_res;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = step_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = step_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg      <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg      <= frame_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

### test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfe_pkg::*;

    localparam logic [2:0] ADDR_FIELD_OFFSET = 3'd0;
    localparam logic [2:0] ADDR_FIELD_SIZE = 3'd4;
    localparam int ITEM_TARGET = 1350;
    localparam int DRAIN_CYCLES = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS = 100;

    class length_scoreboard;
        logic [OFFSET_W-1:0] field_offset;
        logic [SIZE_W-1:0]   field_size;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  acc;
        logic                reported;
        result_t             expected_lengths[$];
        int                  errors;

        function new();
            field_offset = '0;
            field_size = 4'd2;
            pos = '0;
            acc = '0;
            reported = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return expected_lengths.size();
        endfunction

        function void add_expected(logic [VALUE_W-1:0] value, status_t st);
            result_t r;
            r.value = value;
            r.status = st;
            expected_lengths.push_back(r);
            reported = 1'b1;
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [OFFSET_W-1:0] eff;
            logic [SIZE_W-1:0]   mag;
            logic [POS_W-1:0]    idx;
            logic                neg;
            logic                varint;
            logic                good;
            eff = (field_offset > 7'(MAX_OFFSET_DEF)) ? 7'(MAX_OFFSET_DEF) : field_offset;
            neg = field_size[SIZE_W-1];
            mag = neg ? 4'(-field_size) : field_size;
            varint = (field_size == 4'd0);
            good = varint || mag == 4'd1 || mag == 4'd2 || mag == 4'd4;
            if (!reported)
            begin
                if (pos >= eff && pos < POS_LIMIT)
                begin
                    idx = pos - eff;
                    if (varint)
                    begin
                        if (idx < VARINT_MAX)
                        begin
                            acc = acc + (32'(b[6:0]) << (VARINT_BITS * idx));
                            if (!b[7])
                                add_expected(acc, ST_OK);
                            else if (idx == VARINT_MAX - 7'd1)
                                add_expected('0, ST_LONG);
                        end
                    end
                    else if (idx < 7'(mag))
                    begin
                        if (good)
                            acc = neg ? {acc[23:0], b} : (acc | (32'(b) << (8 * idx)));
                        if (idx == 7'(mag) - 7'd1)
                        begin
                            if (good)
                                add_expected(acc, ST_OK);
                            else
                                add_expected('0, ST_BADSIZE);
                        end
                    end
                end
                if (pos < POS_LIMIT)
                    pos = pos + 7'd1;
                if (!reported && last)
                begin
                    if (varint && pos >= eff)
                        add_expected('0, ST_TRUNC);
                    else
                        add_expected('0, ST_SHORT);
                end
            end
            if (last)
            begin
                pos = '0;
                acc = '0;
                reported = 1'b0;
            end
        endfunction

        function void check_result(logic [VALUE_W-1:0] value, logic [2:0] st);
            result_t want;
            if (expected_lengths.size() == 0)
            begin
                report("unexpected result", 32'hffff_ffff, {value[28:0], st});
            end
            else
            begin
                want = expected_lengths.pop_front();
                if (value !== want.value)
                    report("length_value", want.value, value);
                if (st !== want.status)
                    report("status", 32'(want.status), 32'(st));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [VALUE_W-1:0] length_value;
    logic [2:0]  status;

    length_scoreboard length_sb = new();
    int  idle_cycles = 0;
    int  bytes_sent = 0;
    int  cur_offset = 0;
    int  cur_size = 2;
    bit  quiet = 1'b0;

    length_field_extractor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .length_value(length_value),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                length_sb.check_result(length_value, status);
            if (byte_valid && byte_ready)
                length_sb.note_byte(data_byte, last_byte);
            if ((result_valid && result_ready) || (byte_valid && byte_ready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (length_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input int off, input int sz);
        wait_drained();
        write_reg(ADDR_FIELD_OFFSET, 32'(off) & 32'h7f);
        length_sb.field_offset = 7'(off);
        write_reg(ADDR_FIELD_SIZE, 32'(sz) & 32'hf);
        length_sb.field_size = 4'(sz);
        cur_offset = off;
        cur_size = sz;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (!byte_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input int len, input logic [63:0] data);
        for (int p = 0; p < len; p++)
            send_byte(data[8*p +: 8], p == len - 1);
    endtask

    task automatic random_frame();
        int eff;
        int mag;
        int cont;
        int flen;
        int len;
        int kind;
        int idx;
        bit varint;
        logic [7:0] b;
        eff = (cur_offset > MAX_OFFSET_DEF) ? MAX_OFFSET_DEF : cur_offset;
        varint = (cur_size == 0);
        mag = (cur_size < 0) ? -cur_size : cur_size;
        cont = $urandom_range(0, 5);
        flen = varint ? ((cont < 5) ? cont + 1 : 5) : mag;
        kind = $urandom_range(0, 99);
        if (kind < 12)
            len = $urandom_range(1, eff + flen);
        else if (kind < 20)
            len = $urandom_range(1, 12);
        else if (kind < 22)
            len = $urandom_range(128, 136);
        else
            len = eff + flen + $urandom_range(0, 3);
        for (int p = 0; p < len; p++)
        begin
            b = 8'($urandom);
            idx = p - eff;
            if (varint && kind >= 20 && idx >= 0 && idx < 5)
                b[7] = (idx < cont);
            send_byte(b, p == len - 1);
        end
    endtask

    initial
    begin
        int r;
        int off_pick;
        int size_pick;
        int frames;
        int valid_sizes[7];
        valid_sizes = '{1, 2, 4, -1, -2, -4, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(2, 64'h12_34);
        apply_config(0, 1);
        send_frame(1, 64'hff);
        apply_config(0, -2);
        send_frame(2, 64'h00_ab);
        apply_config(0, 4);
        send_frame(4, 64'h04_03_02_01);
        send_frame(2, 64'hff_00);
        apply_config(0, -4);
        send_frame(4, 64'hff_00_00_80);
        apply_config(0, 0);
        send_frame(5, 64'h7f_ff_ff_ff_ff);
        send_frame(5, 64'hff_ff_ff_ff_ff);
        send_frame(1, 64'h80);
        apply_config(1, 0);
        send_frame(1, 64'h00);
        apply_config(0, 3);
        send_frame(3, 64'h33_22_11);
        apply_config(127, -8);
        send_frame(2, 64'h00_ff);
        apply_config(1, 2);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hc3, 1'b0);
        apply_config(1, -4);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        apply_config(0, 7);

        while (bytes_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                off_pick = $urandom_range(0, 4);
            else if (r < 8)
                off_pick = $urandom_range(5, 20);
            else if (r == 8)
                off_pick = $urandom_range(63, 65);
            else
                off_pick = $urandom_range(0, 127);
            if ($urandom_range(0, 9) < 7)
                size_pick = valid_sizes[$urandom_range(0, 6)];
            else
                size_pick = int'($urandom_range(0, 15)) - 8;
            apply_config(off_pick, size_pick);
            quiet = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(4, 16);
            repeat (frames)
            begin
                if (bytes_sent < ITEM_TARGET)
                    random_frame();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (length_sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### length_field_extractor.f
hdl/lfe_pkg.sv
hdl/lfe_step.sv
hdl/length_field_extractor.sv
test/tb_top.sv
